// File: rtl/page_frame_allocator_with_guard_unit_defines.svh
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Shared property forms used by the allocator's checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_WITH_GUARD_UNIT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_WITH_GUARD_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define PFA_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfa: same-cycle property violated");

// Next-cycle implication, sampled on clock and disabled in reset.
`define PFA_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfa: next-cycle property violated");

`endif

// File: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Field widths, command codes, status codes and access rights.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int CMD_W    = 2;
   localparam int USER_W   = 8;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 32;
   localparam int RIGHTS_W = 3;
   localparam int STATUS_W = 4;
   localparam int PADDR_W  = 24;

   typedef logic [CMD_W-1:0]    command_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [RIGHTS_W-1:0] rights_type;

   localparam command_type CMD_ALLOC = 2'd0;
   localparam command_type CMD_FREE  = 2'd1;
   localparam command_type CMD_CHECK = 2'd2;

   localparam status_type ST_OK         = 4'd0;
   localparam status_type ST_NO_USER    = 4'd1;
   localparam status_type ST_BAD_SIZE   = 4'd2;
   localparam status_type ST_NO_MEMORY  = 4'd3;
   localparam status_type ST_TABLE_FULL = 4'd4;
   localparam status_type ST_NULL       = 4'd5;
   localparam status_type ST_OVERFLOW   = 4'd6;
   localparam status_type ST_BOUNDS     = 4'd7;
   localparam status_type ST_MISALIGNED = 4'd8;
   localparam status_type ST_DENIED     = 4'd9;
   localparam status_type ST_WRONG_OWN  = 4'd10;
   localparam status_type ST_UNREG      = 4'd11;

   localparam rights_type RIGHT_READ  = 3'b001;
   localparam rights_type RIGHT_WRITE = 3'b010;
   localparam rights_type RIGHT_EXEC  = 3'b100;
   localparam rights_type RIGHT_ALL   = RIGHT_READ | RIGHT_WRITE | RIGHT_EXEC;
   localparam rights_type RIGHT_RW    = RIGHT_READ | RIGHT_WRITE;

   localparam int CSR_AW = 3;

endpackage

// File: rtl/pfa_req_if.sv
// ----------------------------------------------------------------------------
// Page frame allocator request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface pfa_req_if
   import pfa_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [USER_W-1:0]       user_id;
   logic [ADDR_W-1:0]       address;
   logic [SIZE_W-1:0]       request_size;
   logic [RIGHTS_W-1:0]     access_kind;

   modport source (output valid, command, user_id, address, request_size, access_kind,
                   input ready);
   modport sink   (input valid, command, user_id, address, request_size, access_kind,
                   output ready);
endinterface

// File: rtl/pfa_rsp_if.sv
// ----------------------------------------------------------------------------
// Page frame allocator response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface pfa_rsp_if
   import pfa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PADDR_W-1:0]   page_address;

   modport source (output valid, status, page_address, input ready);
   modport sink   (input valid, status, page_address, output ready);
endinterface

// File: rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// Page frame allocator generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/page_frame_allocator_with_guard_unit.sv
// ----------------------------------------------------------------------------
// Page frame allocator with access guard
// Bitmap page allocator with a search hint and a table of owned regions,
// driven by a small sequencer around one shared compare unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  req_chan  in         valid/ready          command, user, address, size, kind
//  rsp_chan  out        valid/ready          status, page address
//  psel...   in         APB write, no wait   protection enable at 0x0
//
// After reset the block sweeps every entry of the page map, writing the
// reserved region entry on the first, before it takes its first item. Every
// item passes through accept, decode and hand-off. An allocate reads and checks
// bitmap bits one by one from the hint; a check, or a free with protection on,
// scans the region entries, and a free that passes scans again for the entry
// to drop and moves each later entry down. Each RAM has a single read port, so
// every scan reads one entry at a time. A finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
`include "page_frame_allocator_with_guard_unit_defines.svh"

module page_frame_allocator_with_guard_unit
   import pfa_pkg::*;
#(
   parameter int PAGE_COUNT     = 4096,
   parameter int RESERVED_PAGES = 256,
   parameter int REGION_SLOTS   = 1024,
   parameter int PAGE_BYTES     = 4096
) (
   input  logic              clock,
   input  logic              reset,
   pfa_req_if.sink           req_chan,
   pfa_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   localparam int FRAME_W  = $clog2(PAGE_COUNT);
   localparam int HINT_MAX = (PAGE_COUNT > RESERVED_PAGES) ? PAGE_COUNT : RESERVED_PAGES;
   localparam int HINT_W   = $clog2(HINT_MAX + 1);
   localparam int PB_W     = $clog2(PAGE_BYTES);
   localparam int IDX_W    = $clog2(REGION_SLOTS);
   localparam int CNT_W    = $clog2(REGION_SLOTS + 1);
   localparam int LEN_W    = $clog2(RESERVED_PAGES + 1);
   localparam int REG_W    = FRAME_W + LEN_W + RIGHTS_W + USER_W;
   localparam int CW       = (FRAME_W + PB_W + 2 > 34) ? FRAME_W + PB_W + 2 : 34;

   localparam logic [CW-1:0] RESERVED_END = CW'(RESERVED_PAGES) << PB_W;
   localparam logic [CW-1:0] MEM_END      = CW'(PAGE_COUNT) << PB_W;
   localparam logic [CW-1:0] ADDR_TOP     = CW'(32'hFFFF_FFFF);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_DECIDE = 12'b0000_0000_0100,
      S_PRD    = 12'b0000_0000_1000,
      S_PCK    = 12'b0000_0001_0000,
      S_RRD    = 12'b0000_0010_0000,
      S_RCK    = 12'b0000_0100_0000,
      S_DRD    = 12'b0000_1000_0000,
      S_DCK    = 12'b0001_0000_0000,
      S_SRD    = 12'b0010_0000_0000,
      S_SWR    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [FRAME_W-1:0]   clr_ff, clr_in;
   logic                 prot_ff, prot_in;
   logic [HINT_W-1:0]    hint_ff, hint_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [HINT_W-1:0]    pidx_ff, pidx_in;
   logic [CNT_W-1:0]     ridx_ff, ridx_in;
   command_type          cmd_ff, cmd_in;
   logic [USER_W-1:0]    user_ff, user_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [SIZE_W-1:0]    gsize_ff, gsize_in;
   rights_type           gkind_ff, gkind_in;
   status_type           status_ff, status_in;
   logic [PADDR_W-1:0]   paddr_ff, paddr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PADDR_W-1:0]   rsp_paddr_ff, rsp_paddr_in;

   logic                 pg_we, pg_wd, pg_rd;
   logic [FRAME_W-1:0]   pg_wa;
   logic                 rg_we;
   logic [IDX_W-1:0]     rg_wa, rg_ra;
   logic [REG_W-1:0]     rg_wd, rg_rd;

   logic [FRAME_W-1:0]   e_frame;
   logic [LEN_W-1:0]     e_len;
   rights_type           e_rights;
   logic [USER_W-1:0]    e_owner;
   logic [CW-1:0]        addr_cw, end_cw, base_cw, top_cw, frame_cw;
   logic                 covered, req_acc, csr_wr, rsp_load;
   status_type           pre_status;
   logic [CNT_W-1:0]     ridx_p1;

   pfa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_page_map (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_wa),
      .wr_data (pg_wd),
      .rd_addr (pidx_ff[FRAME_W-1:0]),
      .rd_data (pg_rd)
   );

   pfa_ram #(.WIDTH(REG_W), .DEPTH(REGION_SLOTS)) u_region_tab (
      .clock   (clock),
      .wr_en   (rg_we),
      .wr_addr (rg_wa),
      .wr_data (rg_wd),
      .rd_addr (rg_ra),
      .rd_data (rg_rd)
   );

   assign req_acc = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_wr = psel && penable && pwrite && !paddr[2];
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {31'd0, prot_ff};

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.page_address = rsp_paddr_ff;

   assign e_frame  = rg_rd[REG_W-1 -: FRAME_W];
   assign e_len    = rg_rd[USER_W + RIGHTS_W +: LEN_W];
   assign e_rights = rg_rd[USER_W +: RIGHTS_W];
   assign e_owner  = rg_rd[USER_W-1:0];

   assign addr_cw  = CW'(addr_ff);
   assign end_cw   = addr_cw + CW'(gsize_ff);
   assign frame_cw = addr_cw >> PB_W;
   assign base_cw  = CW'(e_frame) << PB_W;
   assign top_cw   = (CW'(e_frame) + CW'(e_len)) << PB_W;
   assign covered  = (addr_cw >= base_cw) && (end_cw <= top_cw);
   assign ridx_p1  = ridx_ff + CNT_W'(1);
   assign rg_ra    = (state_ff == S_SRD) ? ridx_p1[IDX_W-1:0] : ridx_ff[IDX_W-1:0];

   always_comb begin
      if (addr_ff == '0 || gsize_ff == '0) begin
         pre_status = ST_NULL;
      end else if (end_cw > ADDR_TOP) begin
         pre_status = ST_OVERFLOW;
      end else if (addr_cw < RESERVED_END || end_cw > MEM_END) begin
         pre_status = ST_BOUNDS;
      end else if (addr_ff[PB_W-1:0] != '0) begin
         pre_status = ST_MISALIGNED;
      end else begin
         pre_status = ST_OK;
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      prot_in   = csr_wr ? pwdata[0] : prot_ff;
      hint_in   = hint_ff;
      count_in  = count_ff;
      pidx_in   = pidx_ff;
      ridx_in   = ridx_ff;
      cmd_in    = cmd_ff;
      user_in   = user_ff;
      addr_in   = addr_ff;
      size_in   = size_ff;
      gsize_in  = gsize_ff;
      gkind_in  = gkind_ff;
      status_in = status_ff;
      paddr_in  = paddr_ff;
      pg_we     = 1'b0;
      pg_wa     = pidx_ff[FRAME_W-1:0];
      pg_wd     = 1'b0;
      rg_we     = 1'b0;
      rg_wa     = count_ff[IDX_W-1:0];
      rg_wd     = {FRAME_W'(0), LEN_W'(RESERVED_PAGES), RIGHT_ALL, USER_W'(0)};
      rsp_load  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            pg_we = 1'b1;
            pg_wa = clr_ff;
            pg_wd = (CW'(clr_ff) < CW'(RESERVED_PAGES));
            if (clr_ff == '0) begin
               rg_we = 1'b1;
               rg_wa = '0;
            end
            clr_in = clr_ff + FRAME_W'(1);
            if (clr_ff == FRAME_W'(PAGE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in    = req_chan.command;
               user_in   = req_chan.user_id;
               addr_in   = req_chan.address;
               size_in   = req_chan.request_size;
               paddr_in  = '0;
               status_in = ST_OK;
               if (req_chan.command == CMD_FREE) begin
                  gsize_in = SIZE_W'(PAGE_BYTES);
                  gkind_in = RIGHT_WRITE;
               end else begin
                  gsize_in = req_chan.request_size;
                  gkind_in = req_chan.access_kind;
               end
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            ridx_in  = '0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (user_ff == '0) begin
                     status_in = ST_NO_USER;
                  end else if (size_ff != SIZE_W'(PAGE_BYTES)) begin
                     status_in = ST_BAD_SIZE;
                  end else begin
                     pidx_in  = hint_ff;
                     state_in = S_PRD;
                  end
               end
               CMD_FREE: begin
                  if (addr_ff == '0) begin
                     status_in = ST_NULL;
                  end else if (prot_ff && pre_status != ST_OK) begin
                     status_in = pre_status;
                  end else if (prot_ff) begin
                     state_in = S_RRD;
                  end else if (user_ff == '0) begin
                     status_in = ST_NO_USER;
                  end else if (frame_cw >= CW'(PAGE_COUNT)) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     pg_we = 1'b1;
                     pg_wa = frame_cw[FRAME_W-1:0];
                     if (frame_cw < CW'(hint_ff)) begin
                        hint_in = frame_cw[HINT_W-1:0];
                     end
                     state_in = S_DRD;
                  end
               end
               CMD_CHECK: begin
                  if (prot_ff && pre_status != ST_OK) begin
                     status_in = pre_status;
                  end else if (prot_ff) begin
                     state_in = S_RRD;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_PRD: begin
            if (pidx_ff >= HINT_W'(PAGE_COUNT)) begin
               status_in = ST_NO_MEMORY;
               state_in  = S_DONE;
            end else begin
               state_in = S_PCK;
            end
         end
         S_PCK: begin
            if (!pg_rd) begin
               hint_in  = pidx_ff + HINT_W'(1);
               state_in = S_DONE;
               if (count_ff >= CNT_W'(REGION_SLOTS)) begin
                  status_in = ST_TABLE_FULL;
               end else begin
                  pg_we     = 1'b1;
                  pg_wd     = 1'b1;
                  rg_we     = 1'b1;
                  rg_wd     = {pidx_ff[FRAME_W-1:0], LEN_W'(1), RIGHT_RW, user_ff};
                  count_in  = count_ff + CNT_W'(1);
                  paddr_in  = PADDR_W'(CW'(pidx_ff) << PB_W);
               end
            end else begin
               pidx_in  = pidx_ff + HINT_W'(1);
               state_in = S_PRD;
            end
         end
         S_RRD: begin
            if (ridx_ff >= count_ff) begin
               status_in = ST_UNREG;
               state_in  = S_DONE;
            end else begin
               state_in = S_RCK;
            end
         end
         S_RCK: begin
            if (covered) begin
               state_in = S_DONE;
               if ((e_rights & gkind_ff) == '0) begin
                  status_in = ST_DENIED;
               end else if (e_owner != '0 && e_owner != user_ff) begin
                  status_in = ST_WRONG_OWN;
               end else if (cmd_ff == CMD_FREE) begin
                  if (user_ff == '0) begin
                     status_in = ST_NO_USER;
                  end else if (frame_cw >= CW'(PAGE_COUNT)) begin
                     status_in = ST_BOUNDS;
                  end else begin
                     pg_we = 1'b1;
                     pg_wa = frame_cw[FRAME_W-1:0];
                     if (frame_cw < CW'(hint_ff)) begin
                        hint_in = frame_cw[HINT_W-1:0];
                     end
                     ridx_in  = '0;
                     state_in = S_DRD;
                  end
               end
            end else begin
               ridx_in  = ridx_p1;
               state_in = S_RRD;
            end
         end
         S_DRD: begin
            if (ridx_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DCK;
            end
         end
         S_DCK: begin
            if (base_cw == addr_cw) begin
               state_in = S_SRD;
            end else begin
               ridx_in  = ridx_p1;
               state_in = S_DRD;
            end
         end
         S_SRD: begin
            if (ridx_p1 >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_SWR;
            end
         end
         S_SWR: begin
            rg_we    = 1'b1;
            rg_wa    = ridx_ff[IDX_W-1:0];
            rg_wd    = rg_rd;
            ridx_in  = ridx_p1;
            state_in = S_SRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_paddr_in  = paddr_ff;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
         rsp_status_in = rsp_status_ff;
         rsp_paddr_in  = rsp_paddr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         prot_ff      <= 1'b1;
         hint_ff      <= HINT_W'(RESERVED_PAGES);
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         prot_ff      <= prot_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      ridx_ff       <= ridx_in;
      cmd_ff        <= cmd_in;
      user_ff       <= user_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      gsize_ff      <= gsize_in;
      gkind_ff      <= gkind_in;
      status_ff     <= status_in;
      paddr_ff      <= paddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_paddr_ff  <= rsp_paddr_in;
   end

   `PFA_CHECK(a_count_bound, 1'b1, count_ff <= CNT_W'(REGION_SLOTS))
   `PFA_CHECK(a_hint_bound, state_ff == S_IDLE, hint_ff <= HINT_W'(HINT_MAX))
   `PFA_CHECK_NEXT(a_accept_busy, req_acc, state_ff == S_DECIDE && !req_chan.ready)

endmodule
